// File: rtl/msw_pkg.sv
// package: request/result structs, state codes and fixed constants of the sequence weighting core
package msw_pkg;

    localparam int unsigned ONE_Q16  = 65536;
    localparam int unsigned CNT_SAT  = 511;
    localparam int unsigned EFF_SAT  = 33554431;
    localparam logic [15:0] THR_RST  = 16'd52429;
    localparam int unsigned DIV_BITS = 17;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [2:0] symbol;
        logic       last_in_seq;
        logic       last_in_set;
        logic [7:0] seq_index;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  out_index;
        logic [8:0]  neighbour_count;
        logic [16:0] weight_q16;
        logic [24:0] eff_count_q16;
        logic [8:0]  num_seqs;
        logic [8:0]  seq_len;
        logic        error;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_CMP,
        S_DRAIN,
        S_DIV,
        S_WRITE,
        S_FIN,
        S_READ
    } t_state;

endpackage

// File: rtl/msa_sequence_weighting_core.sv
// top level: alignment loader, all-pairs identity pass and per-sequence weight readout
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_ready | msw_pkg::t_in
//  out     | output    | o_out_valid/i_out_ready | msw_pkg::t_out
//  cfg     | input     | i_cfg_valid/o_cfg_ready | 16-bit identity threshold
//
// load symbols are accepted one per cycle while idle and the output register is free, one symbol store write each.
// the closing symbol starts the pass: setup, then paired store reads (two read ports) over all
// sequence pairs and positions, per sequence a drain, the restoring divider and a write, then finish.
// a read request passes the registered count/weight memory read and S_READ into the output register.
// reset (synchronous, active low) clears control state and loads the default threshold only, no sweep.
// a full output register stalls requests until it is taken.
module msa_sequence_weighting_core #(
    parameter int MAX_SEQS    = 256,
    parameter int MAX_LEN     = 256,
    parameter int NUM_SYMBOLS = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  msw_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output msw_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);
    import msw_pkg::*;

    localparam int DEPTH = MAX_SEQS * MAX_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_SEQS);
    localparam int LW    = $clog2(MAX_SEQS + 1);
    localparam int CW    = LW;
    localparam int LNW   = $clog2(MAX_LEN + 1);
    localparam int SYW   = $clog2(NUM_SYMBOLS);
    localparam int CMPW  = (LW > 8) ? LW : 8;
    localparam int CXW   = (CW > 9) ? CW : 9;
    localparam int MW    = 16 + LNW;
    localparam int BW    = AW + 1;

    logic [SYW-1:0] sym_mem [DEPTH];
    logic [25:0]    cw_mem  [MAX_SEQS];

    t_state r_state, n_state;

    logic [15:0]    r_thr;
    logic [LW-1:0]  r_loaded;
    logic [LNW-1:0] r_len;
    logic [LNW-1:0] r_pos;
    logic [BW-1:0]  r_base_ld;
    logic           r_err;
    logic           r_finished;
    logic [24:0]    r_eff;

    logic [LW-1:0]  r_i, r_j;
    logic [LNW-1:0] r_p;
    logic [BW-1:0]  r_base_i, r_base_j;
    logic [MW-1:0]  r_limit;
    logic [LNW-1:0] r_s;
    logic [CW-1:0]  r_cnt;
    logic           r_v1, r_last_p1, r_self1;
    logic [SYW-1:0] r_rd_a, r_rd_b;

    logic [CW-1:0]  r_rem;
    logic [16:0]    r_quo;
    logic [4:0]     r_div_k;

    logic [25:0]    r_cw_q;
    logic [7:0]     r_rd_idx;
    logic           r_rd_bad;

    logic           r_out_valid;
    t_out           r_out;

    // request decode
    logic           in_acc, ld_acc, rd_acc;
    logic [CMPW-1:0] idx_w;
    logic [5:0]     sym6, sym_c;
    logic [LW-1:0]  ld_loaded;
    logic [LNW-1:0] ld_len, ld_pos;
    logic [BW-1:0]  ld_base;
    logic           ld_err;

    // pass datapath
    logic [BW-1:0]  sum_w, sum_a, sum_b;
    logic [AW-1:0]  addr_a, addr_b, addr_w;
    logic           last_p, last_j, last_i;
    logic [LNW-1:0] s_new;
    logic [MW-1:0]  s_sh;
    logic [CW:0]    rem_sh;
    logic           q_bit;
    logic [CXW-1:0] cnt_x;
    logic [8:0]     cnt_sat;
    logic [25:0]    eff_sum;

    assign in_acc = i_in_valid && o_in_ready;
    assign ld_acc = in_acc && (i_in.req_type == REQ_LOAD);
    assign rd_acc = in_acc && (i_in.req_type == REQ_READ);
    assign idx_w  = CMPW'(i_in.seq_index);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        sym6  = 6'(i_in.symbol);
        sym_c = (sym6 >= 6'(NUM_SYMBOLS)) ? 6'(NUM_SYMBOLS - 1) : sym6;
        // the first load after a done result starts a fresh alignment
        ld_loaded = r_finished ? '0 : r_loaded;
        ld_len    = r_finished ? '0 : r_len;
        ld_pos    = r_finished ? '0 : r_pos;
        ld_base   = r_finished ? '0 : r_base_ld;
        ld_err    = r_finished ? 1'b0 : r_err;
    end

    assign sum_w  = ld_base + BW'(ld_pos);
    assign sum_a  = r_base_i + BW'(r_p);
    assign sum_b  = r_base_j + BW'(r_p);
    assign addr_w = sum_w[AW-1:0];
    assign addr_a = sum_a[AW-1:0];
    assign addr_b = sum_b[AW-1:0];
    assign last_p = (r_p == r_len - LNW'(1));
    assign last_j = (r_j == r_loaded - LW'(1));
    assign last_i = (r_i == r_loaded - LW'(1));
    assign s_new  = r_s + LNW'(r_rd_a == r_rd_b);
    assign s_sh   = {s_new, 16'h0};
    assign rem_sh = {r_rem, r_quo[16]};
    assign q_bit  = (rem_sh >= (CW+1)'(r_cnt));
    assign cnt_x  = CXW'(r_cnt);
    assign cnt_sat = (cnt_x > CXW'(CNT_SAT)) ? 9'(CNT_SAT) : 9'(cnt_x);
    assign eff_sum = 26'(r_eff) + 26'(r_quo);

    // symbol store: one write port for loading, two read ports for the pass
    always_ff @(posedge i_clk) begin
        if (ld_acc && (ld_loaded < LW'(MAX_SEQS)) && (ld_pos < LNW'(MAX_LEN))) begin
            sym_mem[addr_w] <= SYW'(sym_c);
        end
        r_rd_a <= sym_mem[addr_a];
        r_rd_b <= sym_mem[addr_b];
    end

    // count/weight store
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            cw_mem[r_i[SW-1:0]] <= {cnt_sat, r_quo};
        end
        r_cw_q <= cw_mem[idx_w[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (in_acc) begin
                    if (i_in.req_type == REQ_READ) begin
                        n_state = S_READ;
                    end else if (i_in.last_in_set) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: n_state = (r_loaded == '0) ? S_FIN : S_CMP;
            S_CMP:   if (last_p && last_j) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DIV;
            S_DIV:   if (r_div_k == 5'd1) n_state = S_WRITE;
            S_WRITE: n_state = last_i ? S_FIN : S_CMP;
            S_FIN:   n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RST;
            r_loaded    <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_base_ld   <= '0;
            r_err       <= 1'b0;
            r_finished  <= 1'b0;
            r_eff       <= '0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_v1 <= (r_state == S_CMP);

            // pairwise match accumulation, in the cycle after the registered reads
            if (r_v1) begin
                if (r_last_p1) begin
                    r_s <= '0;
                    if (r_self1 || (s_sh > r_limit)) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end else begin
                    r_s <= s_new;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (ld_acc) begin
                        logic [LW-1:0]  v_loaded;
                        logic [LNW-1:0] v_len, v_pos;
                        logic [BW-1:0]  v_base;
                        logic           v_err;
                        v_loaded = ld_loaded;
                        v_len    = ld_len;
                        v_pos    = ld_pos;
                        v_base   = ld_base;
                        v_err    = ld_err;
                        if (r_finished) begin
                            r_eff <= '0;
                        end
                        r_finished <= 1'b0;
                        if ((v_loaded < LW'(MAX_SEQS)) && (v_pos < LNW'(MAX_LEN))) begin
                            v_pos = v_pos + LNW'(1);
                        end else begin
                            v_err = 1'b1;
                        end
                        if (i_in.last_in_seq || i_in.last_in_set) begin
                            if (v_loaded >= LW'(MAX_SEQS)) begin
                                v_err = 1'b1;
                            end else if (v_loaded == '0) begin
                                v_len    = v_pos;
                                v_loaded = LW'(1);
                                v_base   = v_base + BW'(MAX_LEN);
                            end else if (v_pos != v_len) begin
                                v_err = 1'b1;
                            end else begin
                                v_loaded = v_loaded + LW'(1);
                                v_base   = v_base + BW'(MAX_LEN);
                            end
                            v_pos = '0;
                        end
                        r_loaded  <= v_loaded;
                        r_len     <= v_len;
                        r_pos     <= v_pos;
                        r_base_ld <= v_base;
                        r_err     <= v_err;
                    end
                    if (rd_acc) begin
                        r_rd_idx <= i_in.seq_index;
                        r_rd_bad <= (idx_w >= CMPW'(r_loaded));
                    end
                end
                S_SETUP: begin
                    r_limit  <= MW'(r_thr) * MW'(r_len);
                    r_i      <= '0;
                    r_j      <= '0;
                    r_p      <= '0;
                    r_base_i <= '0;
                    r_base_j <= '0;
                    r_s      <= '0;
                    r_cnt    <= '0;
                    r_eff    <= '0;
                end
                S_CMP: begin
                    r_last_p1 <= last_p;
                    r_self1   <= (r_i == r_j);
                    if (last_p) begin
                        r_p <= '0;
                        if (last_j) begin
                            r_j      <= '0;
                            r_base_j <= '0;
                        end else begin
                            r_j      <= r_j + LW'(1);
                            r_base_j <= r_base_j + BW'(MAX_LEN);
                        end
                    end else begin
                        r_p <= r_p + LNW'(1);
                    end
                end
                S_DRAIN: begin
                    r_div_k <= 5'(DIV_BITS);
                    r_rem   <= '0;
                    r_quo   <= 17'(ONE_Q16);
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_rem   <= q_bit ? CW'(rem_sh - (CW+1)'(r_cnt)) : CW'(rem_sh);
                    r_quo   <= {r_quo[15:0], q_bit};
                    r_div_k <= r_div_k - 5'd1;
                end
                S_WRITE: begin
                    r_eff    <= (eff_sum > 26'(EFF_SAT)) ? 25'(EFF_SAT) : 25'(eff_sum);
                    r_cnt    <= '0;
                    r_i      <= r_i + LW'(1);
                    r_base_i <= r_base_i + BW'(MAX_LEN);
                end
                S_FIN: begin
                    r_finished  <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_out.result_kind     <= KIND_DONE;
                    r_out.out_index       <= '0;
                    r_out.neighbour_count <= '0;
                    r_out.weight_q16      <= '0;
                    r_out.eff_count_q16   <= r_eff;
                    r_out.num_seqs        <= 9'(r_loaded);
                    r_out.seq_len         <= 9'(r_len);
                    r_out.error           <= r_err;
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out.result_kind   <= KIND_READ;
                    r_out.out_index     <= r_rd_idx;
                    r_out.eff_count_q16 <= r_eff;
                    r_out.num_seqs      <= 9'(r_loaded);
                    r_out.seq_len       <= 9'(r_len);
                    if (r_rd_bad) begin
                        r_out.neighbour_count <= '0;
                        r_out.weight_q16      <= '0;
                        r_out.error           <= 1'b1;
                    end else begin
                        // before a pass the stored results read as zero
                        r_out.neighbour_count <= r_finished ? r_cw_q[25:17] : '0;
                        r_out.weight_q16      <= r_finished ? r_cw_q[16:0] : '0;
                        r_out.error           <= r_err;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_set_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_acc && i_in.last_in_set) |=> !o_in_ready)
        else $error("request accepted while the pass starts");

    a_read_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |-> ##2 o_out_valid)
        else $error("readout not delivered two cycles after its request");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != '0))
        else $error("divider started with zero neighbour count");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) || (r_state == S_READ)) |-> !r_out_valid)
        else $error("result written over a pending result");

endmodule
